@@ rtl/msgpack_map_key_search_unit_assert.svh @@
// Assertion macros for the MessagePack key search unit
`ifndef MSGPACK_MAP_KEY_SEARCH_UNIT_ASSERT_SVH
`define MSGPACK_MAP_KEY_SEARCH_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset
`define MKS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication outside reset
`define MKS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/mks_pkg.sv @@
// ----------------------------------------------------------------------------
// mks_pkg
// Types and constants shared by the MessagePack key search unit.
// ----------------------------------------------------------------------------
`default_nettype none
package mks_pkg;
  localparam int DATA_W = 8;
  localparam int CNT_W  = 32;
  localparam int TOP_W  = 33;
  localparam int KEY_W  = 64;
  localparam int KLEN_W = 4;
  localparam int DEP_W  = 5;

  // header kinds
  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ARRAY   = 2'd2,
    KIND_MAP     = 2'd3
  } kind_t;

  // register indexes
  localparam logic CFG_KEY_VALUE  = 1'b0;
  localparam logic CFG_KEY_LENGTH = 1'b1;

  // queued item between front and back
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              first_byte;
    logic [CNT_W-1:0]  entry_count;
  } item_t;

  // result item
  typedef struct packed {
    logic             value_start;
    logic             found;
    logic             search_done;
    logic             parse_error;
    logic [DEP_W-1:0] depth;
  } res_t;
endpackage
`default_nettype wire

@@ rtl/mks_fifo.sv @@
// ----------------------------------------------------------------------------
// mks_fifo
// Two-entry item queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
module mks_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire mks_pkg::item_t in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mks_pkg::item_t     out_item
);
  import mks_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end

  `include "msgpack_map_key_search_unit_assert.svh"
  `MKS_ASSERT_IMP(a_fifo_cnt, 1'b1, cnt_r != 2'd3, "queue count out of range")
  `MKS_ASSERT_NXT(a_fifo_push, push && !pop, cnt_r != 2'd0, "push lost")
  `MKS_ASSERT_NXT(a_fifo_pop, pop && !push && cnt_r == 2'd1, cnt_r == 2'd0, "pop lost")
endmodule
`default_nettype wire

@@ rtl/mks_walker.sv @@
// ----------------------------------------------------------------------------
// mks_walker
// Back part: walks headers, payloads and nesting one byte per cycle unless the result output stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module mks_walker #(
  parameter int STACK_DEPTH   = 16,
  parameter int KEY_MAX_BYTES = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [mks_pkg::KEY_W-1:0]  key_value,
  input  wire logic [mks_pkg::KLEN_W-1:0] key_length,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire mks_pkg::item_t         in_item,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output mks_pkg::res_t               out_res
);
  import mks_pkg::*;
  localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LV_W = $clog2(STACK_DEPTH + 1);

  logic [TOP_W-1:0] stack_r [STACK_DEPTH];
  logic [LV_W-1:0]  lvl_r, lvl_nxt;
  logic [2:0]       hdr_r, hdr_nxt;
  kind_t            kind_r, kind_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] pay_r, pay_nxt;
  logic [TOP_W-1:0] top_r, top_nxt;
  logic             cmp_r, cmp_nxt, pend_r, pend_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic             fnd_r, fnd_nxt;
  logic             ov_r;
  res_t             res_r;
  logic             fire, err, vstart;
  logic             fin, opn;
  logic [TOP_W-1:0] opn_cnt;
  logic             sp_len_v;
  logic [CNT_W-1:0] sp_len;
  logic             bc;
  logic [7:0]       b;
  logic [TOP_W-1:0] top_tmp;
  logic             push_w;
  logic [SP_W-1:0]  push_idx;
  logic [TOP_W-1:0] tos, tos_dec;

  assign in_ready = !ov_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_res   = res_r;
  assign b = in_item.data_byte;

  // byte decode and state update
  always_comb begin
    logic [3:0] p;
    logic [2:0] sh;
    logic [7:0] kb;
    logic [LV_W-1:0] l;
    logic stop;
    lvl_nxt = lvl_r; hdr_nxt = hdr_r; kind_nxt = kind_r; acc_nxt = acc_r;
    pay_nxt = pay_r; top_nxt = top_r; cmp_nxt = cmp_r; pend_nxt = pend_r;
    pos_nxt = pos_r; fnd_nxt = fnd_r;
    err = 1'b0; vstart = 1'b0; fin = 1'b0; opn = 1'b0; opn_cnt = '0;
    sp_len_v = 1'b0; sp_len = '0; bc = 1'b0;
    push_w = 1'b0; push_idx = '0; p = '0; sh = '0; kb = '0; l = '0; stop = 1'b0;
    tos = '0; tos_dec = '0;
    if (in_item.first_byte) begin
      lvl_nxt = '0; hdr_nxt = '0; kind_nxt = KIND_NONE; acc_nxt = '0; pay_nxt = '0;
      cmp_nxt = 1'b0; pend_nxt = 1'b0; pos_nxt = '0; fnd_nxt = 1'b0;
      top_nxt = {in_item.entry_count, 1'b0};
    end
    top_tmp = top_nxt;
    if (top_tmp != '0) begin
      if (hdr_nxt != 3'd0) begin
        acc_nxt = {acc_nxt[CNT_W-9:0], b};
        hdr_nxt = hdr_nxt - 3'd1;
        if (hdr_nxt == 3'd0) begin
          kind_nxt = KIND_NONE;
          case (kind_r)
            KIND_ARRAY: begin opn = 1'b1; opn_cnt = {1'b0, acc_nxt}; end
            KIND_MAP:   begin opn = 1'b1; opn_cnt = {acc_nxt, 1'b0}; end
            default:    begin sp_len_v = 1'b1; sp_len = acc_nxt; end
          endcase
        end
      end else if (pay_nxt != '0) begin
        if (cmp_nxt) begin
          p  = pos_nxt;
          sh = 3'(key_length - 4'd1 - p);
          kb = key_value[{sh, 3'b000} +: 8];
          if (p >= key_length || kb != b) cmp_nxt = 1'b0;
          else pos_nxt = p + 4'd1;
        end
        pay_nxt = pay_nxt - CNT_W'(1);
        if (pay_nxt == '0) fin = 1'b1;
      end else begin
        if (pend_nxt) begin vstart = 1'b1; pend_nxt = 1'b0; end
        if (b <= 8'h7f || b >= 8'he0) fin = 1'b1;
        else if (b <= 8'h8f) begin opn = 1'b1; opn_cnt = TOP_W'({b[3:0], 1'b0}); end
        else if (b <= 8'h9f) begin opn = 1'b1; opn_cnt = TOP_W'(b[3:0]); end
        else if (b <= 8'hbf) begin bc = 1'b1; sp_len_v = 1'b1; sp_len = CNT_W'(b[4:0]); end
        else begin
          case (b)
            8'hc0, 8'hc2, 8'hc3: fin = 1'b1;
            8'hc4: begin hdr_nxt = 3'd1; kind_nxt = KIND_PAYLOAD; acc_nxt = '0; end
            8'hc5: begin hdr_nxt = 3'd2; kind_nxt = KIND_PAYLOAD; acc_nxt = '0; end
            8'hc6: begin hdr_nxt = 3'd4; kind_nxt = KIND_PAYLOAD; acc_nxt = '0; end
            8'hcc, 8'hd0: pay_nxt = CNT_W'(1);
            8'hcd, 8'hd1: pay_nxt = CNT_W'(2);
            8'hca, 8'hce, 8'hd2: pay_nxt = CNT_W'(4);
            8'hcb, 8'hcf, 8'hd3: pay_nxt = CNT_W'(8);
            8'hd9: begin bc = 1'b1; hdr_nxt = 3'd1; kind_nxt = KIND_PAYLOAD; acc_nxt = '0; end
            8'hda: begin bc = 1'b1; hdr_nxt = 3'd2; kind_nxt = KIND_PAYLOAD; acc_nxt = '0; end
            8'hdb: begin bc = 1'b1; hdr_nxt = 3'd4; kind_nxt = KIND_PAYLOAD; acc_nxt = '0; end
            8'hdc: begin hdr_nxt = 3'd2; kind_nxt = KIND_ARRAY; acc_nxt = '0; end
            8'hdd: begin hdr_nxt = 3'd4; kind_nxt = KIND_ARRAY; acc_nxt = '0; end
            8'hde: begin hdr_nxt = 3'd2; kind_nxt = KIND_MAP; acc_nxt = '0; end
            8'hdf: begin hdr_nxt = 3'd4; kind_nxt = KIND_MAP; acc_nxt = '0; end
            default: err = 1'b1;
          endcase
        end
        // start a key compare on a top-level string key
        if (bc && lvl_nxt == '0 && !top_tmp[0] && key_length <= 4'(KEY_MAX_BYTES)) begin
          cmp_nxt = 1'b1; pos_nxt = '0;
        end
      end
      // payload start
      if (sp_len_v) begin
        if (cmp_nxt && sp_len != CNT_W'(key_length)) cmp_nxt = 1'b0;
        if (sp_len == '0) fin = 1'b1;
        else pay_nxt = sp_len;
      end
      // container open
      if (opn) begin
        if (opn_cnt == '0) fin = 1'b1;
        else if (lvl_nxt >= LV_W'(STACK_DEPTH)) err = 1'b1;
        else begin push_w = 1'b1; push_idx = SP_W'(lvl_nxt); lvl_nxt = lvl_nxt + LV_W'(1); end
      end
      // object end: every open level with one object left closes; the first
      // level below them with more left counts the object and stays open
      if (fin) begin
        l = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
          if (LV_W'(i) < lvl_nxt && stack_r[i] != TOP_W'(1)) l = LV_W'(i + 1);
        end
        if (l != '0) begin
          push_w = 1'b1; push_idx = SP_W'(l - LV_W'(1));
          tos = stack_r[push_idx]; tos_dec = tos - TOP_W'(1);
          stop = 1'b1;
        end
        lvl_nxt = l;
        if (!stop && l == '0) begin
          if (cmp_nxt) begin cmp_nxt = 1'b0; pend_nxt = 1'b1; fnd_nxt = 1'b1; end
          if (top_nxt != '0) top_nxt = top_nxt - TOP_W'(1);
        end
      end
      if (err) begin
        lvl_nxt = '0; hdr_nxt = '0; kind_nxt = KIND_NONE; acc_nxt = '0; pay_nxt = '0;
        top_nxt = '0; cmp_nxt = 1'b0; pend_nxt = 1'b0; pos_nxt = '0;
      end
    end
  end

  // Stack write
  always_ff @(posedge clk) begin
    if (fire && push_w && !err) begin
      if (opn && !fin) stack_r[push_idx] <= opn_cnt;
      else stack_r[push_idx] <= tos_dec;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r <= '0; hdr_r <= '0; kind_r <= KIND_NONE; acc_r <= '0; pay_r <= '0;
      top_r <= '0; cmp_r <= 1'b0; pend_r <= 1'b0; pos_r <= '0; fnd_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (fire) begin
        lvl_r <= lvl_nxt; hdr_r <= hdr_nxt; kind_r <= kind_nxt; acc_r <= acc_nxt;
        pay_r <= pay_nxt; top_r <= top_nxt; cmp_r <= cmp_nxt; pend_r <= pend_nxt;
        pos_r <= pos_nxt; fnd_r <= fnd_nxt;
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r.value_start <= vstart;
      res_r.found       <= fnd_nxt;
      res_r.search_done <= (top_nxt == '0);
      res_r.parse_error <= err;
      res_r.depth       <= DEP_W'(lvl_nxt);
    end
  end

  `include "msgpack_map_key_search_unit_assert.svh"
  `MKS_ASSERT_IMP(a_lvl_range, 1'b1, lvl_r <= LV_W'(STACK_DEPTH), "nesting level overflow")
  `MKS_ASSERT_IMP(a_err_done, ov_r && res_r.parse_error, res_r.search_done, "error not done")
  `MKS_ASSERT_IMP(a_done_idle, top_r == '0, lvl_r == '0 && !cmp_r, "idle walk state dirty")
endmodule
`default_nettype wire

@@ rtl/msgpack_map_key_search_unit.sv @@
// Path: an accepted byte is held in the input queue, then the walker registers
// its result in the output register.
// Throughput: one byte per cycle unless the output stalls; counters and stack top update per byte.
// The input queue (two entries) and output register let each side stall alone.
// Reset: rst_n synchronous, active low; clears walk state and key registers.
// The nesting stack has no reset; entries are written before they are read.
`default_nettype none
module msgpack_map_key_search_unit #(
  parameter int STACK_DEPTH   = 16,
  parameter int KEY_MAX_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // data_byte[7:0], entry_count[39:8]
  input  wire logic        in_tuser,   // first_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // value_start, found, search_done, parse_error, depth[8:4]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  import mks_pkg::*;

  logic [KEY_W-1:0]  key_value_r;
  logic [KLEN_W-1:0] key_length_r;
  item_t             fe_item, q_item;
  logic              q_valid, q_ready;
  res_t              res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_value_r <= '0; key_length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_VALUE:  key_value_r  <= cfg_wdata;
        CFG_KEY_LENGTH: key_length_r <= cfg_wdata[KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // front: unpack item
  assign fe_item.data_byte   = in_tdata[7:0];
  assign fe_item.entry_count = in_tdata[39:8];
  assign fe_item.first_byte  = in_tuser;

  mks_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_item(fe_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
  );

  mks_walker #(.STACK_DEPTH(STACK_DEPTH), .KEY_MAX_BYTES(KEY_MAX_BYTES)) u_walk (
    .clk(clk), .rst_n(rst_n),
    .key_value(key_value_r), .key_length(key_length_r),
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {7'd0, res.depth, res.parse_error, res.search_done,
                      res.found, res.value_start};
endmodule
`default_nettype wire

@@ tb/mks_format_pkg.sv @@
// ----------------------------------------------------------------------------
// mks_format_pkg
// MessagePack type bytes used by the key search checker and stimulus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mks_format_pkg;
  localparam logic [7:0] FMT_FIXMAP   = 8'h80;
  localparam logic [7:0] FMT_FIXARR   = 8'h90;
  localparam logic [7:0] FMT_FIXSTR   = 8'hA0;
  localparam logic [7:0] FMT_NIL      = 8'hC0;
  localparam logic [7:0] FMT_UNUSED   = 8'hC1;
  localparam logic [7:0] FMT_FALSE    = 8'hC2;
  localparam logic [7:0] FMT_TRUE     = 8'hC3;
  localparam logic [7:0] FMT_BIN8     = 8'hC4;
  localparam logic [7:0] FMT_BIN16    = 8'hC5;
  localparam logic [7:0] FMT_BIN32    = 8'hC6;
  localparam logic [7:0] FMT_EXT8     = 8'hC7;
  localparam logic [7:0] FMT_EXT32    = 8'hC9;
  localparam logic [7:0] FMT_FLOAT32  = 8'hCA;
  localparam logic [7:0] FMT_FLOAT64  = 8'hCB;
  localparam logic [7:0] FMT_UINT8    = 8'hCC;
  localparam logic [7:0] FMT_UINT16   = 8'hCD;
  localparam logic [7:0] FMT_UINT32   = 8'hCE;
  localparam logic [7:0] FMT_UINT64   = 8'hCF;
  localparam logic [7:0] FMT_INT8     = 8'hD0;
  localparam logic [7:0] FMT_INT16    = 8'hD1;
  localparam logic [7:0] FMT_INT32    = 8'hD2;
  localparam logic [7:0] FMT_INT64    = 8'hD3;
  localparam logic [7:0] FMT_FIXEXT1  = 8'hD4;
  localparam logic [7:0] FMT_FIXEXT16 = 8'hD8;
  localparam logic [7:0] FMT_STR8     = 8'hD9;
  localparam logic [7:0] FMT_STR16    = 8'hDA;
  localparam logic [7:0] FMT_STR32    = 8'hDB;
  localparam logic [7:0] FMT_ARR16    = 8'hDC;
  localparam logic [7:0] FMT_ARR32    = 8'hDD;
  localparam logic [7:0] FMT_MAP16    = 8'hDE;
  localparam logic [7:0] FMT_MAP32    = 8'hDF;
  localparam logic [7:0] FMT_NEGFIX   = 8'hE0;
endpackage

@@ tb/msgpack_map_key_search_unit_checker.sv @@
// ----------------------------------------------------------------------------
// msgpack_map_key_search_unit_checker
// Watches the byte, result and register ports, walks each accepted byte
// through its own model of the key search and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module msgpack_map_key_search_unit_checker
  import mks_pkg::*;
  import mks_format_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,   // data_byte[7:0], entry_count[39:8]
  input  logic        in_tuser,   // first_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // value_start, found, search_done, parse_error, depth[8:4]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fails,
  output int          pending
);
  localparam int STACK_N = 16;
  localparam int KEY_MAX = 8;

  // searched key
  logic [63:0] key_bytes;
  logic [3:0]  key_len;

  // walk state
  logic [32:0] open_left [0:STACK_N-1];
  logic [4:0]  level;
  logic [2:0]  hdr_left;
  kind_t       hdr_kind;
  logic [31:0] len_acc;
  logic [31:0] skip_left;
  logic [32:0] top_left;
  logic        comparing;
  logic        value_due;
  logic [3:0]  key_pos;
  logic        key_seen;

  res_t result_q[$];

  function automatic void clear_walk();
    level     = '0;
    hdr_left  = '0;
    hdr_kind  = KIND_NONE;
    len_acc   = '0;
    skip_left = '0;
    top_left  = '0;
    comparing = 1'b0;
    value_due = 1'b0;
    key_pos   = '0;
  endfunction

  // an object ended: count it in its parent, popping finished containers
  function automatic void close_object();
    logic inside_open;
    inside_open = 1'b0;
    while (level > 0 && !inside_open) begin
      open_left[level-1] = open_left[level-1] - 33'd1;
      if (open_left[level-1] != 0) inside_open = 1'b1;
      else level = level - 5'd1;
    end
    if (!inside_open) begin
      if (comparing) begin
        comparing = 1'b0;
        value_due = 1'b1;
        key_seen  = 1'b1;
      end
      if (top_left > 0) top_left = top_left - 33'd1;
    end
  endfunction

  function automatic void open_payload(logic [31:0] len);
    if (comparing && len != {28'd0, key_len}) comparing = 1'b0;
    if (len == 0) close_object();
    else skip_left = len;
  endfunction

  // returns 1 on nesting overflow
  function automatic logic open_nest(logic [32:0] cnt);
    if (cnt == 0) begin
      close_object();
      return 1'b0;
    end
    if (level >= STACK_N) return 1'b1;
    open_left[level] = cnt;
    level = level + 5'd1;
    return 1'b0;
  endfunction

  function automatic void open_header(logic [2:0] nbytes, kind_t kind);
    hdr_left = nbytes;
    hdr_kind = kind;
    len_acc  = '0;
  endfunction

  function automatic void arm_compare(logic top_key);
    if (top_key && key_len <= KEY_MAX) begin
      comparing = 1'b1;
      key_pos   = '0;
    end
  endfunction

  function automatic res_t scan_byte(logic [7:0] b, logic first, logic [31:0] cnt);
    logic       err;
    logic       vstart;
    logic       top_key;
    logic [3:0] p;
    logic [2:0] sh;
    kind_t      kind;
    res_t       r;
    err    = 1'b0;
    vstart = 1'b0;
    if (first) begin
      clear_walk();
      key_seen = 1'b0;
      top_left = {cnt, 1'b0};
    end
    if (top_left != 0) begin
      if (hdr_left > 0) begin
        // big-endian length field
        len_acc  = {len_acc[23:0], b};
        hdr_left = hdr_left - 3'd1;
        if (hdr_left == 0) begin
          kind     = hdr_kind;
          hdr_kind = KIND_NONE;
          case (kind)
            KIND_ARRAY: err = open_nest({1'b0, len_acc});
            KIND_MAP:   err = open_nest({len_acc, 1'b0});
            default:    open_payload(len_acc);
          endcase
        end
      end else if (skip_left > 0) begin
        if (comparing) begin
          p  = key_pos;
          sh = 3'(key_len - 4'd1 - p);
          if (p >= key_len || key_bytes[{sh, 3'b000} +: 8] != b) comparing = 1'b0;
          else key_pos = p + 4'd1;
        end
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) close_object();
      end else begin
        // type byte
        top_key = (level == 0) && !top_left[0];
        if (value_due) begin
          vstart    = 1'b1;
          value_due = 1'b0;
        end
        if (b < FMT_FIXMAP || b >= FMT_NEGFIX) close_object();
        else if (b < FMT_FIXARR) err = open_nest({28'd0, b[3:0], 1'b0});
        else if (b < FMT_FIXSTR) err = open_nest({29'd0, b[3:0]});
        else if (b < FMT_NIL) begin
          arm_compare(top_key);
          open_payload({27'd0, b[4:0]});
        end else begin
          case (b)
            FMT_NIL, FMT_FALSE, FMT_TRUE: close_object();
            FMT_BIN8:  open_header(3'd1, KIND_PAYLOAD);
            FMT_BIN16: open_header(3'd2, KIND_PAYLOAD);
            FMT_BIN32: open_header(3'd4, KIND_PAYLOAD);
            FMT_UINT8, FMT_INT8:   skip_left = 32'd1;
            FMT_UINT16, FMT_INT16: skip_left = 32'd2;
            FMT_FLOAT32, FMT_UINT32, FMT_INT32: skip_left = 32'd4;
            FMT_FLOAT64, FMT_UINT64, FMT_INT64: skip_left = 32'd8;
            FMT_STR8: begin
              arm_compare(top_key);
              open_header(3'd1, KIND_PAYLOAD);
            end
            FMT_STR16: begin
              arm_compare(top_key);
              open_header(3'd2, KIND_PAYLOAD);
            end
            FMT_STR32: begin
              arm_compare(top_key);
              open_header(3'd4, KIND_PAYLOAD);
            end
            FMT_ARR16: open_header(3'd2, KIND_ARRAY);
            FMT_ARR32: open_header(3'd4, KIND_ARRAY);
            FMT_MAP16: open_header(3'd2, KIND_MAP);
            FMT_MAP32: open_header(3'd4, KIND_MAP);
            default:   err = 1'b1;
          endcase
        end
      end
      if (err) clear_walk();
    end
    r.value_start = vstart;
    r.found       = key_seen;
    r.search_done = (top_left == 0);
    r.parse_error = err;
    r.depth       = level;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      key_bytes = '0;
      key_len   = '0;
      clear_walk();
      key_seen  = 1'b0;
      result_q.delete();
      fails     = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_KEY_VALUE) key_bytes = cfg_wdata;
        else key_len = cfg_wdata[3:0];
      end
      if (in_tvalid && in_tready)
        result_q.push_back(scan_byte(in_tdata[7:0], in_tuser, in_tdata[39:8]));
      if (out_tvalid && out_tready) begin
        got.value_start = out_tdata[0];
        got.found       = out_tdata[1];
        got.search_done = out_tdata[2];
        got.parse_error = out_tdata[3];
        got.depth       = out_tdata[8:4];
        if (result_q.size() == 0) begin
          $error("unexpected result item %h", out_tdata);
          fails++;
        end else begin
          want = result_q.pop_front();
          if (got.value_start != want.value_start) begin
            $error("value_start: expected %0d, got %0d", want.value_start, got.value_start);
            fails++;
          end
          if (got.found != want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            fails++;
          end
          if (got.search_done != want.search_done) begin
            $error("search_done: expected %0d, got %0d", want.search_done, got.search_done);
            fails++;
          end
          if (got.parse_error != want.parse_error) begin
            $error("parse_error: expected %0d, got %0d", want.parse_error, got.parse_error);
            fails++;
          end
          if (got.depth != want.depth) begin
            $error("depth: expected %0d, got %0d", want.depth, got.depth);
            fails++;
          end
        end
      end
    end
    pending = result_q.size();
  end
endmodule

@@ tb/msgpack_map_key_search_unit_test.sv @@
// ----------------------------------------------------------------------------
// msgpack_map_key_search_unit_test
// Feeds MessagePack map bodies (mostly well formed, some broken or random)
// under several key settings, with random stalls on both sides; the checker
// beside the unit predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module msgpack_map_key_search_unit_test;
  import mks_pkg::*;
  import mks_format_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [63:0] cfg_wdata = '0;
  int          fails;
  int          pending;

  item_t       byte_q[$];
  logic [7:0]  body[$];
  int          n_queued = 0;
  int          n_taken = 0;
  int          send_gap = 0;
  int          recv_gap = 0;
  int          hold_cnt = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  logic        no_idle = 1'b0;
  int          cycles = 0;
  logic [63:0] cur_key;
  int          cur_len;

  msgpack_map_key_search_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  msgpack_map_key_search_unit_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("msgpack_map_key_search_unit regression: fail");
      $finish;
    end
  end

  // mostly short gaps, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // byte sender
  always @(posedge clk) begin
    item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) n_taken <= n_taken + 1;
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (byte_q.size() > 0) begin
          it = byte_q.pop_front();
          in_tdata  <= {it.entry_count, it.data_byte};
          in_tuser  <= it.first_byte;
          in_tvalid <= 1'b1;
          send_gap  <= pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt - 1;
    end else if (hold_req && !hold_taken) begin
      out_tready <= 1'b0;
      hold_cnt   <= 300;
      hold_taken <= 1'b1;
    end else if (recv_gap > 0) begin
      out_tready <= 1'b0;
      recv_gap   <= recv_gap - 1;
    end else begin
      out_tready <= 1'b1;
      recv_gap   <= pick_gap();
    end
  end

  function automatic void push_item(logic [7:0] b, logic first, logic [31:0] cnt);
    item_t it;
    it.data_byte   = b;
    it.first_byte  = first;
    it.entry_count = cnt;
    byte_q.push_back(it);
    n_queued++;
  endfunction

  function automatic void push_len(int nbytes, logic [31:0] v);
    for (int i = nbytes - 1; i >= 0; i--) body.push_back(v[8*i +: 8]);
  endfunction

  function automatic void str_header(int len);
    int f;
    f = (len < 32) ? $urandom_range(0, 3) : $urandom_range(1, 3);
    case (f)
      0: body.push_back(FMT_FIXSTR | 8'(len));
      1: begin body.push_back(FMT_STR8);  push_len(1, len); end
      2: begin body.push_back(FMT_STR16); push_len(2, len); end
      default: begin body.push_back(FMT_STR32); push_len(4, len); end
    endcase
  endfunction

  function automatic logic [7:0] key_byte(int i);
    if (cur_len <= 8 && i < cur_len) return cur_key[8*(cur_len-1-i) +: 8];
    return 8'($urandom);
  endfunction

  function automatic void gen_value(int lvl);
    int sel;
    int n;
    int f;
    sel = $urandom_range(0, 11);
    if (lvl >= 4 && sel >= 5) sel = 0;
    case (sel)
      0: body.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                              : 8'($urandom_range(224, 255)));
      1: begin
        f = $urandom_range(0, 2);
        body.push_back(f == 0 ? FMT_NIL : (f == 1 ? FMT_FALSE : FMT_TRUE));
      end
      2: begin
        f = $urandom_range(0, 9);
        case (f)
          0: begin body.push_back(FMT_UINT8);   n = 1; end
          1: begin body.push_back(FMT_UINT16);  n = 2; end
          2: begin body.push_back(FMT_UINT32);  n = 4; end
          3: begin body.push_back(FMT_UINT64);  n = 8; end
          4: begin body.push_back(FMT_INT8);    n = 1; end
          5: begin body.push_back(FMT_INT16);   n = 2; end
          6: begin body.push_back(FMT_INT32);   n = 4; end
          7: begin body.push_back(FMT_INT64);   n = 8; end
          8: begin body.push_back(FMT_FLOAT32); n = 4; end
          default: begin body.push_back(FMT_FLOAT64); n = 8; end
        endcase
        repeat (n) body.push_back(8'($urandom));
      end
      3: begin
        n = $urandom_range(0, 6);
        str_header(n);
        repeat (n) body.push_back(8'($urandom));
      end
      4: begin
        n = $urandom_range(0, 5);
        f = $urandom_range(0, 2);
        body.push_back(f == 0 ? FMT_BIN8 : (f == 1 ? FMT_BIN16 : FMT_BIN32));
        push_len(f == 0 ? 1 : (f == 1 ? 2 : 4), n);
        repeat (n) body.push_back(8'($urandom));
      end
      5, 6: begin
        n = $urandom_range(0, 3);
        f = $urandom_range(0, 2);
        if (f == 0) body.push_back(FMT_FIXARR | 8'(n));
        else if (f == 1) begin body.push_back(FMT_ARR16); push_len(2, n); end
        else begin body.push_back(FMT_ARR32); push_len(4, n); end
        repeat (n) gen_value(lvl + 1);
      end
      7, 8: begin
        n = $urandom_range(0, 2);
        f = $urandom_range(0, 2);
        if (f == 0) body.push_back(FMT_FIXMAP | 8'(n));
        else if (f == 1) begin body.push_back(FMT_MAP16); push_len(2, n); end
        else begin body.push_back(FMT_MAP32); push_len(4, n); end
        repeat (n) begin
          gen_value(lvl + 1);
          gen_value(lvl + 1);
        end
      end
      default: body.push_back(8'($urandom_range(0, 127)));
    endcase
  endfunction

  // top-level key: half the time the searched key, else near misses or other values
  function automatic void gen_key();
    int r;
    int k;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      str_header(cur_len);
      for (int i = 0; i < cur_len; i++) body.push_back(key_byte(i));
    end else if (r < 62 && cur_len > 0) begin
      k = $urandom_range(0, cur_len - 1);
      str_header(cur_len);
      for (int i = 0; i < cur_len; i++)
        body.push_back(i == k ? key_byte(i) ^ 8'(1 << $urandom_range(0, 7)) : key_byte(i));
    end else if (r < 70) begin
      str_header(cur_len + 1);
      for (int i = 0; i <= cur_len; i++) body.push_back(key_byte(i));
    end else if (r < 78) begin
      body.push_back(FMT_BIN8);
      push_len(1, cur_len);
      for (int i = 0; i < cur_len; i++) body.push_back(key_byte(i));
    end else begin
      gen_value(1);
    end
  endfunction

  function automatic void send_body(logic [31:0] pairs);
    if (body.size() == 0) push_item(8'($urandom), 1'b1, pairs);
    for (int i = 0; i < body.size(); i++)
      push_item(body[i], i == 0, i == 0 ? pairs : 32'($urandom));
    // trailing bytes, ignored once the search is done
    repeat ($urandom_range(0, 2)) push_item(8'($urandom), 1'b0, 32'($urandom));
  endfunction

  function automatic void gen_search(int pairs, logic broken);
    int p;
    int r;
    logic [7:0] bad;
    body.delete();
    repeat (pairs) begin
      gen_key();
      gen_value(0);
    end
    if (broken && body.size() > 1) begin
      p = $urandom_range(0, body.size() - 1);
      r = $urandom_range(0, 4);
      case (r)
        0: bad = FMT_UNUSED;
        1: bad = FMT_EXT8;
        2: bad = FMT_EXT32;
        3: bad = FMT_FIXEXT1;
        default: bad = FMT_FIXEXT16;
      endcase
      if ($urandom_range(0, 2) == 0) body[p] = 8'($urandom);
      else body[p] = bad;
      if ($urandom_range(0, 3) == 0) while (body.size() > p + 1) void'(body.pop_back());
    end
    send_body(pairs);
  endfunction

  // nested arrays of one element; depth past the stack raises an error
  function automatic void gen_nest(int levels);
    body.delete();
    str_header(cur_len);
    for (int i = 0; i < cur_len; i++) body.push_back(key_byte(i));
    repeat (levels) body.push_back(FMT_FIXARR | 8'd1);
    body.push_back(8'h7F);
    body.push_back(FMT_NIL);
    body.push_back(FMT_TRUE);
    send_body(2);
  endfunction

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (n_taken != n_queued || pending != 0 || in_tvalid);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_key(logic [63:0] kv, int kl);
    cur_key = kv;
    cur_len = kl;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_KEY_VALUE;
    cfg_wdata <= kv;
    @(posedge clk);
    cfg_index <= CFG_KEY_LENGTH;
    cfg_wdata <= 64'(kl);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int start;
    int r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: set_key({32'd0, 32'h006B6579}, 3);
        1: set_key('0, 0);
        2: set_key('1, 8);
        3: set_key('0, 8);
        4: set_key(64'($urandom), 1);
        5: set_key({$urandom, $urandom}, 12);
        6: set_key({$urandom, $urandom}, 15);
        default: set_key({$urandom, $urandom}, $urandom_range(1, 8));
      endcase
      no_idle = (ph == 3);
      if (ph == 0) begin
        // empty map, single pair, duplicates, errors, deepest legal nest, nest overflow
        body.delete();
        send_body(0);
        gen_search(1, 1'b0);
        body.delete();
        repeat (2) begin
          str_header(3);
          for (int i = 0; i < 3; i++) body.push_back(key_byte(i));
          body.push_back(FMT_UINT8);
          body.push_back(8'hFF);
        end
        send_body(2);
        body.delete();
        body.push_back(FMT_UNUSED);
        send_body(1);
        body.delete();
        body.push_back(FMT_FIXSTR | 8'd3);
        for (int i = 0; i < 3; i++) body.push_back(key_byte(i));
        body.push_back(FMT_FIXEXT1);
        send_body(1);
        gen_nest(16);
        gen_nest(17);
        body.delete();
        repeat (4) body.push_back(8'($urandom));
        send_body(32'hFFFF_FFFF);
      end
      start = n_queued;
      if (ph == 2) hold_req = 1'b1;
      while (n_queued - start < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 70) gen_search($urandom_range(1, 4), 1'b0);
        else if (r < 78) gen_search(0, 1'b0);
        else if (r < 88) gen_search($urandom_range(1, 4), 1'b1);
        else if (r < 92) gen_nest($urandom_range(14, 18));
        else begin
          body.delete();
          repeat ($urandom_range(5, 15)) body.push_back(8'($urandom));
          send_body($urandom);
        end
      end
      wait_idle();
    end
    repeat (10) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("msgpack_map_key_search_unit regression: pass");
    else
      $display("msgpack_map_key_search_unit regression: fail");
    $finish;
  end
endmodule
